[rtl/fba_pkg.sv]
// Shared types and constants for the fit block allocator.
// Used by fba_ctrl, fba_datapath and fit_block_allocator_core; depends on nothing.
package fba_pkg;

  localparam int unsigned BLOCKS     = 16;
  localparam int unsigned SIZE_BITS  = 16;
  localparam int unsigned IDX_BITS   = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int unsigned LIMIT_BITS = $clog2(BLOCKS + 1);

  localparam int unsigned MODE_BITS   = 2;
  localparam int unsigned ACTIVE_BITS = 5;
  localparam int unsigned CFG_BITS    = 5;
  localparam int unsigned CHOSEN_BITS = 4;
  localparam int unsigned VALUE_BITS  = 16;

  localparam logic CFG_FIT_MODE = 1'b0;
  localparam logic CFG_ACTIVE   = 1'b1;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = ACTIVE_BITS'(16);

  typedef enum logic [MODE_BITS-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic req_start;
    logic scan_rd;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic limit_zero;
  } dp_status_t;

endpackage

[rtl/fit_block_allocator_core.sv]
// Top level of the fit block allocator: configuration registers, controller and datapath.
// Depends on fba_pkg, fba_ctrl and fba_datapath.
//
// A load item is written to the table at the accepting edge: busy_o stays low and start_i
// may be high again in the next cycle. A request item scans the table through one read
// port, one entry per cycle, over min(active_blocks, 16) entries; its result appears
// with done_o high for one cycle, and the next item can be taken once done_o has fallen.
// The result cannot be held off: done_o marks the cycle in which it is complete, and
// the outputs keep it until the next request item is accepted.
module fit_block_allocator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [fba_pkg::CFG_BITS-1:0]    cfg_wdata_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            kind_i,
  input  logic [3:0]                      block_index_i,
  input  logic [15:0]                     size_value_i,
  output logic                            done_o,
  output logic                            granted_o,
  output logic [3:0]                      chosen_block_o,
  output logic [15:0]                     block_left_o
);

  logic [fba_pkg::MODE_BITS-1:0]   fit_mode_q;
  logic [fba_pkg::ACTIVE_BITS-1:0] active_blocks_q;

  fba_pkg::dp_cmd_t    cmd;
  fba_pkg::dp_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q      <= fba_pkg::FIT_FIRST;
      active_blocks_q <= fba_pkg::ACTIVE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fba_pkg::CFG_FIT_MODE) begin
        fit_mode_q <= cfg_wdata_i[fba_pkg::MODE_BITS-1:0];
      end else if (cfg_idx_i == fba_pkg::CFG_ACTIVE) begin
        active_blocks_q <= cfg_wdata_i[fba_pkg::ACTIVE_BITS-1:0];
      end
    end
  end

  fba_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .kind_i   (kind_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  fba_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .fit_mode_i      (fit_mode_q),
    .active_blocks_i (active_blocks_q),
    .block_index_i   (block_index_i),
    .size_value_i    (size_value_i),
    .granted_o       (granted_o),
    .chosen_block_o  (chosen_block_o),
    .block_left_o    (block_left_o)
  );

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o held for more than one cycle");

  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && kind_i == fba_pkg::KIND_REQUEST) |=> busy_o)
    else $error("request item accepted but block not busy");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && kind_i == fba_pkg::KIND_LOAD) |=> (!busy_o && !done_o))
    else $error("load item started a search or produced an item");

  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("block stayed busy after delivering its item");

endmodule

[rtl/fba_ctrl.sv]
// Controller state machine of the fit block allocator.
// Depends on fba_pkg; drives the command struct of fba_datapath.
module fba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               kind_i,
  input  fba_pkg::dp_status_t status_i,
  output fba_pkg::dp_cmd_t    cmd_o,
  output logic               busy_o,
  output logic               done_o
);

  fba_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fba_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      fba_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          if (kind_i == fba_pkg::KIND_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.req_start = 1'b1;
            state_d         = fba_pkg::ST_SCAN;
          end
        end
      end
      fba_pkg::ST_SCAN: begin
        if (status_i.limit_zero) begin
          state_d = fba_pkg::ST_FINISH;
        end else begin
          cmd_o.scan_rd = 1'b1;
          if (status_i.scan_last) begin
            state_d = fba_pkg::ST_DRAIN;
          end
        end
      end
      fba_pkg::ST_DRAIN: begin
        state_d = fba_pkg::ST_FINISH;
      end
      fba_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        done_o       = 1'b1;
        state_d      = fba_pkg::ST_IDLE;
      end
      default: begin
        state_d = fba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/fba_datapath.sv]
// Datapath of the fit block allocator: free size table, scan counter and selection.
// Depends on fba_pkg; steered by fba_ctrl through the command struct.
module fba_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fba_pkg::dp_cmd_t                   cmd_i,
  output fba_pkg::dp_status_t                status_o,
  input  logic [fba_pkg::MODE_BITS-1:0]      fit_mode_i,
  input  logic [fba_pkg::ACTIVE_BITS-1:0]    active_blocks_i,
  input  logic [3:0]                         block_index_i,
  input  logic [15:0]                        size_value_i,
  output logic                               granted_o,
  output logic [fba_pkg::CHOSEN_BITS-1:0]    chosen_block_o,
  output logic [fba_pkg::VALUE_BITS-1:0]     block_left_o
);

  localparam int unsigned IB = fba_pkg::IDX_BITS;
  localparam int unsigned SB = fba_pkg::SIZE_BITS;
  localparam int unsigned LB = fba_pkg::LIMIT_BITS;

  logic [SB-1:0]              mem_q [fba_pkg::BLOCKS];
  logic [fba_pkg::BLOCKS-1:0] valid_q;

  logic [SB-1:0] size_q;
  logic [LB-1:0] limit_q, limit_d;
  logic [IB-1:0] cnt_q;
  logic          ev_q;
  logic [IB-1:0] ev_idx_q;
  logic [SB-1:0] rd_q;
  logic          rd_vld_q;
  logic          found_q;
  logic [IB-1:0] best_idx_q;
  logic [SB-1:0] best_val_q;

  logic [SB-1:0] cand;
  logic          fits;
  logic          take;
  logic [SB-1:0] left;
  logic [IB-1:0] load_idx;
  logic [SB-1:0] load_val;

  assign load_idx = IB'(block_index_i);
  assign load_val = SB'(size_value_i);

  always_comb begin
    if (active_blocks_i > fba_pkg::ACTIVE_BITS'(fba_pkg::BLOCKS)) begin
      limit_d = LB'(fba_pkg::BLOCKS);
    end else begin
      limit_d = LB'(active_blocks_i);
    end
  end

  assign status_o.limit_zero = (limit_q == '0);
  assign status_o.scan_last  = (LB'(cnt_q) == LB'(limit_q - 1'b1));

  assign cand = rd_vld_q ? rd_q : '0;
  assign fits = (cand >= size_q);

  always_comb begin
    take = 1'b0;
    if (ev_q && fits) begin
      if (!found_q) begin
        take = 1'b1;
      end else if (fit_mode_i == fba_pkg::FIT_BEST) begin
        take = (cand < best_val_q);
      end else if (fit_mode_i == fba_pkg::FIT_WORST) begin
        take = (cand > best_val_q);
      end
    end
  end

  assign left = best_val_q - size_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (32'(block_index_i) < fba_pkg::BLOCKS)) begin
      mem_q[load_idx] <= load_val;
    end else if (cmd_i.finish && found_q) begin
      mem_q[best_idx_q] <= left;
    end
    if (cmd_i.scan_rd) begin
      rd_q <= mem_q[cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      ev_q     <= 1'b0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      cnt_q    <= '0;
      limit_q  <= '0;
    end else begin
      if (cmd_i.load && (32'(block_index_i) < fba_pkg::BLOCKS)) begin
        valid_q[load_idx] <= 1'b1;
      end else if (cmd_i.finish && found_q) begin
        valid_q[best_idx_q] <= 1'b1;
      end
      ev_q <= cmd_i.scan_rd;
      if (cmd_i.scan_rd) begin
        rd_vld_q <= valid_q[cnt_q];
        cnt_q    <= cnt_q + 1'b1;
      end
      if (cmd_i.req_start) begin
        found_q <= 1'b0;
        cnt_q   <= '0;
        limit_q <= limit_d;
      end else if (take) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_start) begin
      size_q     <= load_val;
      best_idx_q <= '0;
      best_val_q <= '0;
    end else if (take) begin
      best_idx_q <= ev_idx_q;
      best_val_q <= cand;
    end
    if (cmd_i.scan_rd) begin
      ev_idx_q <= cnt_q;
    end
  end

  assign granted_o      = found_q;
  assign chosen_block_o = found_q ? fba_pkg::CHOSEN_BITS'(best_idx_q) : '0;
  assign block_left_o   = found_q ? fba_pkg::VALUE_BITS'(left) : '0;

endmodule
